// ===== rtl/srtl_pkg.sv =====
// ----------------------------------------------------------------------------
// srtl_pkg: shared definitions for the range table lookup unit
// Request codes, the command that moves from the front end to the table
// engine, and the width of the reported entry index.
// ----------------------------------------------------------------------------
package srtl_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned FI_W   = 10;

  typedef enum logic [1:0] {
    ACT_TEXT   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic {
    CMD_STORE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] limit;
  } cmd_t;

endpackage

// ===== rtl/srtl_front.sv =====
// ----------------------------------------------------------------------------
// srtl_front: request intake and symbol text parser
// Accepts requests, parses symbol text records and turns complete records,
// direct adds and lookups into commands for the table engine.
// ----------------------------------------------------------------------------
module srtl_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     action,
  input  logic [7:0]                     text_byte,
  input  logic                           text_last,
  input  logic [srtl_pkg::ADDR_W-1:0]    range_start,
  input  logic [srtl_pkg::ADDR_W-1:0]    range_end,
  input  logic [srtl_pkg::ADDR_W-1:0]    address,
  input  logic                           q_full,
  output logic                           q_push,
  output srtl_pkg::cmd_t                 q_cmd
);
  import srtl_pkg::*;

  typedef enum logic [1:0] {
    PH_BLANK = 2'd0,
    PH_START = 2'd1,
    PH_END   = 2'd2,
    PH_NAME  = 2'd3
  } phase_t;

  phase_t            phase, phase_next, phase_eff;
  logic [ADDR_W-1:0] start_accum, start_accum_next;
  logic [ADDR_W-1:0] end_accum, end_accum_next;
  logic              in_fire;
  logic              is_blank;
  logic [4:0]        hex;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign is_blank = (text_byte == 8'h20) || (text_byte == 8'h09) || (text_byte == 8'h0a);
  assign hex      = hex_decode(text_byte);
  assign phase_eff = (phase == PH_BLANK) ? PH_START : phase;

  always_comb begin
    phase_next       = phase;
    start_accum_next = start_accum;
    end_accum_next   = end_accum;
    q_push           = 1'b0;
    q_cmd.op         = CMD_STORE;
    q_cmd.first      = start_accum;
    q_cmd.limit      = end_accum;
    if (in_fire) begin
      unique case (action_t'(action))
        ACT_TEXT: begin
          if (!(phase == PH_BLANK && is_blank)) begin
            unique case (phase_eff)
              PH_START: begin
                if (text_byte == ",") begin
                  phase_next = PH_END;
                end else if (hex[4]) begin
                  phase_next       = PH_START;
                  start_accum_next = {start_accum[ADDR_W-5:0], hex[3:0]};
                end else begin
                  phase_next = PH_START;
                end
              end
              PH_END: begin
                if (text_byte == ",") begin
                  phase_next = PH_NAME;
                end else if (hex[4]) begin
                  end_accum_next = {end_accum[ADDR_W-5:0], hex[3:0]};
                end
              end
              default: begin
                if (text_byte == 8'h00) begin
                  q_push           = (start_accum != '0) && (end_accum > start_accum);
                  phase_next       = PH_BLANK;
                  start_accum_next = '0;
                  end_accum_next   = '0;
                end
              end
            endcase
          end
          if (text_last) begin
            phase_next       = PH_BLANK;
            start_accum_next = '0;
            end_accum_next   = '0;
          end
        end
        ACT_ADD: begin
          q_push      = 1'b1;
          q_cmd.first = range_start;
          q_cmd.limit = range_end;
        end
        ACT_LOOKUP: begin
          q_push      = 1'b1;
          q_cmd.op    = CMD_LOOKUP;
          q_cmd.first = address;
          q_cmd.limit = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_BLANK;
      start_accum <= '0;
      end_accum   <= '0;
    end else begin
      phase       <= phase_next;
      start_accum <= start_accum_next;
      end_accum   <= end_accum_next;
    end
  end

endmodule

// ===== rtl/srtl_queue.sv =====
// ----------------------------------------------------------------------------
// srtl_queue: two-entry command queue
// Decouples the front end from the table engine so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module srtl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  srtl_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output srtl_pkg::cmd_t head
);
  import srtl_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign avail = (fill != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/srtl_back.sv =====
// ----------------------------------------------------------------------------
// srtl_back: range table engine
// Holds the range memory and entry count, stores ranges and walks the table
// one entry per cycle to answer lookups.
// ----------------------------------------------------------------------------
module srtl_back #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned IDX_W       = 10,
  parameter int unsigned CNT_W       = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_avail,
  input  srtl_pkg::cmd_t               q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [srtl_pkg::FI_W-1:0]    function_index,
  output logic [CNT_W-1:0]             entry_count
);
  import srtl_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] limit;
  } entry_t;

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data;
  state_t            state;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  issue_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_valid;
  logic              has_room;
  logic              wr_en;
  logic              hit;
  logic [IDX_W+FI_W-1:0] idx_wide;

  assign has_room = (entry_count < CNT_W'(TABLE_DEPTH));
  assign q_pop    = q_avail && (state == ST_IDLE) &&
                    ((q_head.op == CMD_STORE) || !out_valid || out_ready);
  assign wr_en    = q_pop && (q_head.op == CMD_STORE) && has_room;
  assign hit      = (addr >= rd_data.first) && (addr < rd_data.limit);
  assign idx_wide = {{FI_W{1'b0}}, rd_idx};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[entry_count[IDX_W-1:0]] <= '{first: q_head.first, limit: q_head.limit};
    end
    rd_data <= mem[issue_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      entry_count <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_head.op == CMD_STORE) begin
              if (has_room) begin
                entry_count <= entry_count + CNT_W'(1);
              end
            end else begin
              addr      <= q_head.first;
              issue_idx <= '0;
              rd_valid  <= 1'b0;
              state     <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (rd_valid && hit) begin
            out_valid      <= 1'b1;
            found          <= 1'b1;
            function_index <= idx_wide[FI_W-1:0];
            rd_valid       <= 1'b0;
            state          <= ST_IDLE;
          end else if (!rd_valid && (issue_idx >= entry_count)) begin
            out_valid      <= 1'b1;
            found          <= 1'b0;
            function_index <= '0;
            state          <= ST_IDLE;
          end else if (issue_idx < entry_count) begin
            rd_valid  <= 1'b1;
            rd_idx    <= issue_idx[IDX_W-1:0];
            issue_idx <= issue_idx + CNT_W'(1);
          end else begin
            rd_valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/symbol_range_table_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// symbol_range_table_lookup_unit: address range table with text loader
// Top level joining the parser front end, command queue and table engine.
// ----------------------------------------------------------------------------
// Text bytes and unused requests are consumed by the front end; a direct
// add or a completed record is written into the range memory, if the table
// has room, at the edge that takes it out of the two-entry command queue. A
// lookup walks the table through the single read port of the range memory,
// one entry per cycle. A hit reports the first matching entry, and a miss is
// reported once every entry has been read. Requests keep entering while a
// lookup walks until the queue holds two commands, and a result waiting in
// the output register does not block stores. The memory needs no clearing
// pass after reset.
module symbol_range_table_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [7:0]                  text_byte,
  input  logic                        text_last,
  input  logic [srtl_pkg::ADDR_W-1:0] range_start,
  input  logic [srtl_pkg::ADDR_W-1:0] range_end,
  input  logic [srtl_pkg::ADDR_W-1:0] address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [srtl_pkg::FI_W-1:0]   function_index
);
  import srtl_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  cmd_t             push_cmd;
  cmd_t             head;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_avail;
  logic [CNT_W-1:0] entry_count;

  srtl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .text_byte   (text_byte),
    .text_last   (text_last),
    .range_start (range_start),
    .range_end   (range_end),
    .address     (address),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  srtl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (head)
  );

  srtl_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_avail        (q_avail),
    .q_head         (head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .function_index (function_index),
    .entry_count    (entry_count)
  );

  a_not_found_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> function_index == '0)
    else $error("not-found result carries a nonzero index");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_count_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (entry_count != $past(entry_count)) |->
      entry_count == $past(entry_count) + CNT_W'(1))
    else $error("entry count changed by other than one");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("command pushed into a full queue");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: range table lookup unit
// Drives symbol text records, direct adds and lookups through the request
// channel, keeps its own copy of the table and text parser, and checks every
// lookup result against it. Records are mostly well formed with random
// content; truncated records, noise bytes and unused requests are mixed in.
// The run ends by filling the table to capacity and probing it.
// ----------------------------------------------------------------------------
module testbench;
  import srtl_pkg::*;

  localparam int TABLE_SLOTS = 256;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [63:0] TOP_FIRST = 64'hFFFF_FFFF_0000_0000;

  typedef enum logic [1:0] {
    PH_BLANK = 2'd0,
    PH_START = 2'd1,
    PH_END   = 2'd2,
    PH_NAME  = 2'd3
  } parse_phase_t;

  typedef struct packed {
    logic            found;
    logic [FI_W-1:0] idx;
  } lookup_result_t;

  class range_table_scoreboard;
    logic [63:0]    first_tab [TABLE_SLOTS];
    logic [63:0]    limit_tab [TABLE_SLOTS];
    int unsigned    count;
    parse_phase_t   phase;
    logic [63:0]    start_acc;
    logic [63:0]    end_acc;
    lookup_result_t pending_lookups [$];
    int unsigned    errors, text_bytes, adds, lookups, hits, misses, dropped;

    function new();
      count = 0;
      clear_record();
    endfunction

    function void clear_record();
      phase = PH_BLANK;
      start_acc = '0;
      end_acc = '0;
    endfunction

    function void store_range(logic [63:0] first, logic [63:0] limit);
      if (count < TABLE_SLOTS) begin
        first_tab[count] = first;
        limit_tab[count] = limit;
        count++;
      end else begin
        dropped++;
      end
    endfunction

    function bit hex_nibble(logic [7:0] c, output logic [3:0] v);
      v = '0;
      if (c >= "0" && c <= "9") v = 4'(c - "0");
      else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function void parse_byte(logic [7:0] c);
      logic [3:0] nib;
      if (phase == PH_BLANK) begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL) return;
        phase = PH_START;
      end
      case (phase)
        PH_START: begin
          if (c == CH_COMMA) phase = PH_END;
          else if (hex_nibble(c, nib)) start_acc = {start_acc[59:0], nib};
        end
        PH_END: begin
          if (c == CH_COMMA) phase = PH_NAME;
          else if (hex_nibble(c, nib)) end_acc = {end_acc[59:0], nib};
        end
        default: begin
          if (c == CH_NUL) begin
            if (start_acc != 0 && end_acc > start_acc) store_range(start_acc, end_acc);
            clear_record();
          end
        end
      endcase
    endfunction

    function void note_request(action_t act, logic [7:0] b, logic last,
                               logic [63:0] rs, logic [63:0] re, logic [63:0] addr);
      lookup_result_t r;
      case (act)
        ACT_TEXT: begin
          text_bytes++;
          parse_byte(b);
          if (last) clear_record();
        end
        ACT_ADD: begin
          adds++;
          store_range(rs, re);
        end
        ACT_LOOKUP: begin
          lookups++;
          r = '0;
          for (int unsigned i = 0; i < count; i++) begin
            if (addr >= first_tab[i] && addr < limit_tab[i]) begin
              r.found = 1'b1;
              r.idx = i[FI_W-1:0];
              break;
            end
          end
          if (r.found) hits++;
          else misses++;
          pending_lookups.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_lookup_result(logic f, logic [FI_W-1:0] idx);
      lookup_result_t want;
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("result found=%0b index=%0d with no lookup outstanding",
                                  f, idx));
        return;
      end
      want = pending_lookups.pop_front();
      if (f !== want.found)
        report_mismatch($sformatf("found=%0b, predicted %0b", f, want.found));
      if (idx !== want.idx)
        report_mismatch($sformatf("function_index=%0d, predicted %0d", idx, want.idx));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        action;
  logic [7:0]        text_byte;
  logic              text_last;
  logic [63:0]       range_start;
  logic [63:0]       range_end;
  logic [63:0]       address;
  logic              out_valid;
  logic              out_ready;
  logic              found;
  logic [FI_W-1:0]   function_index;

  range_table_scoreboard sb;
  logic [7:0] rec_bytes [$];
  int         burst_left;
  logic       hold_req;

  symbol_range_table_lookup_unit #(
    .TABLE_DEPTH (TABLE_SLOTS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .text_byte      (text_byte),
    .text_last      (text_last),
    .range_start    (range_start),
    .range_end      (range_end),
    .address        (address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .function_index (function_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(action_t act, logic [7:0] b, logic last,
                           logic [63:0] rs, logic [63:0] re, logic [63:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    action = act;
    text_byte = b;
    text_last = last;
    range_start = rs;
    range_end = re;
    address = addr;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_request(act, b, last, rs, re, addr);
  endtask

  task automatic send_text(logic [7:0] b, logic last);
    send_item(ACT_TEXT, b, last, rand64(), rand64(), rand64());
  endtask

  task automatic send_add(logic [63:0] s, logic [63:0] e);
    send_item(ACT_ADD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), s, e, rand64());
  endtask

  task automatic send_lookup(logic [63:0] a);
    send_item(ACT_LOOKUP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              rand64(), rand64(), a);
  endtask

  function automatic void pick_range(output logic [63:0] s, output logic [63:0] e);
    case ($urandom_range(0, 9))
      0:       s = '0;
      1, 2:    s = rand64();
      default: s = 64'($urandom_range(1, 8000));
    endcase
    case ($urandom_range(0, 7))
      0:       e = s - 64'($urandom_range(0, 3));
      1:       e = rand64();
      default: e = s + 64'($urandom_range(1, 400));
    endcase
  endfunction

  function automatic logic [63:0] pick_address();
    int unsigned k;
    logic [63:0] base;
    if (sb.count > 0 && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, sb.count - 1);
      base = $urandom_range(0, 1) ? sb.first_tab[k] : sb.limit_tab[k];
      return base + 64'($urandom_range(0, 4)) - 64'd2;
    end
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 9000));
      default: return rand64();
    endcase
  endfunction

  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(8'h00, 8'h2B));
      1:       return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  // Digits above the sixteenth are random and get shifted out by the parser.
  function automatic void push_hex(logic [63:0] v, bit junk);
    int nd;
    logic [3:0] d;
    nd = 16;
    while (nd > 1 && v[4*nd-1 -: 4] == 4'd0) nd--;
    if ($urandom_range(0, 3) == 0) nd += $urandom_range(1, 3);
    for (int k = nd - 1; k >= 0; k--) begin
      d = (k < 16) ? v[4*k +: 4] : 4'($urandom_range(0, 15));
      if (d < 4'd10) rec_bytes.push_back(8'h30 + 8'(d));
      else rec_bytes.push_back(($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(d) - 8'd10);
      if (junk && $urandom_range(0, 4) == 0) rec_bytes.push_back(junk_char());
    end
  endfunction

  task automatic send_record(logic [63:0] s, logic [63:0] e, bit broken);
    bit junk;
    bit last_flag;
    int cut;
    int mid;
    logic [63:0] ms, me;
    junk = ($urandom_range(0, 3) == 0);
    rec_bytes.delete();
    repeat ($urandom_range(0, 2)) rec_bytes.push_back(blank_char());
    push_hex(s, junk);
    rec_bytes.push_back(CH_COMMA);
    push_hex(e, junk);
    rec_bytes.push_back(CH_COMMA);
    repeat ($urandom_range(0, 3)) rec_bytes.push_back(8'($urandom_range(1, 255)));
    rec_bytes.push_back(CH_NUL);
    last_flag = ($urandom_range(0, 7) == 0);
    if (broken) begin
      cut = $urandom_range(1, rec_bytes.size() - 1);
      while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
      last_flag = ($urandom_range(0, 2) != 0);
    end
    mid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, rec_bytes.size() - 1) : -1;
    foreach (rec_bytes[i]) begin
      if (i == mid) begin
        if ($urandom_range(0, 1)) begin
          pick_range(ms, me);
          send_add(ms, me);
        end else begin
          send_lookup(pick_address());
        end
      end
      send_text(rec_bytes[i], last_flag && (i == rec_bytes.size() - 1));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_lookup_result(found, function_index);
  end

  // The receiver switches at random among four stall patterns and holds
  // off completely for a long stretch once the sender asks for it.
  initial begin
    int mode;
    int left;
    bit held;
    mode = 0;
    left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        held = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 150);
      end
      left--;
      case (mode)
        0:       out_ready = 1'b1;
        1:       out_ready = 1'($urandom_range(0, 1));
        2:       out_ready = (left % 4 == 0);
        default: out_ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    #40_000_000;
    $display("Run timed out.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    string rec;
    int r;
    int waited;
    logic [63:0] s, e;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_TEXT;
    text_byte = '0;
    text_last = 1'b0;
    range_start = '0;
    range_end = '0;
    address = '0;
    hold_req = 1'b0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty table, one record with leading blanks and mixed
    // case digits, unchecked adds, extreme addresses, an add that lands in
    // the middle of a record cut short by the last byte, and an unused request.
    send_lookup('0);
    rec = " \t\n1F,2a,z";
    foreach (rec[i]) send_text(rec[i], 1'b0);
    send_text(CH_NUL, 1'b0);
    send_add('0, '0);
    send_add(64'd100, 64'd50);
    send_add('0, 64'd16);
    send_add(64'hFFFF_FFFF_FFFF_FFFE, '1);
    send_lookup(64'h1F);
    send_lookup(64'h2A);
    send_lookup('0);
    send_lookup(64'hFFFF_FFFF_FFFF_FFFE);
    send_lookup('1);
    send_text("5", 1'b0);
    send_add(64'd1000, 64'd2000);
    send_text(CH_COMMA, 1'b0);
    send_text("9", 1'b1);
    send_item(ACT_NONE, 8'hFF, 1'b1, '1, '1, '1);

    // Long receiver hold-off while lookups keep arriving.
    hold_req = 1'b1;
    repeat (6) send_lookup(pick_address());

    while (sb.text_bytes + sb.adds + sb.lookups < 260) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        pick_range(s, e);
        send_record(s, e, 1'b0);
      end else if (r < 33) begin
        pick_range(s, e);
        send_record(s, e, 1'b1);
      end else if (r < 45) begin
        pick_range(s, e);
        send_add(s, e);
      end else if (r < 92) begin
        send_lookup(pick_address());
      end else if (r < 97) begin
        repeat ($urandom_range(1, 3))
          send_text(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end else begin
        send_item(ACT_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  rand64(), rand64(), rand64());
      end
    end

    // Fill the table, then show that further stores are dropped.
    while (sb.count < TABLE_SLOTS) begin
      if (sb.count == TABLE_SLOTS - 1) begin
        send_add(TOP_FIRST, TOP_FIRST + 64'h100);
      end else begin
        s = 64'($urandom_range(1, 60000));
        send_add(s, s + 64'($urandom_range(1, 64)));
      end
    end
    send_record(64'h20, 64'h30, 1'b0);
    send_add(64'h1, 64'h2);
    repeat (28) send_lookup(pick_address());
    send_lookup(TOP_FIRST + 64'h5);
    send_lookup('1);

    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (sb.pending_lookups.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending_lookups.size() != 0) begin
      $display("Timed out with %0d lookup results outstanding.", sb.pending_lookups.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      repeat (50) @(posedge clk);
      $display("Sent %0d text bytes, %0d direct adds and %0d lookups (%0d hits, %0d misses).",
               sb.text_bytes, sb.adds, sb.lookups, sb.hits, sb.misses);
      $display("Table held %0d entries at the end; %0d stores were refused while full.",
               sb.count, sb.dropped);
      if (sb.errors == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/srtl_pkg.sv
rtl/srtl_front.sv
rtl/srtl_queue.sv
rtl/srtl_back.sv
rtl/symbol_range_table_lookup_unit.sv
tb/testbench.sv
